>>> rtl/srsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared widths, command codes, status codes and register map of the
// selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Field widths of the request and result beats
  localparam int CMD_W      = 2;
  localparam int SEQ_W      = 8;
  localparam int PAY_W      = 64;
  localparam int STATUS_W   = 3;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int WSIZE_W    = 4;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd4;

  // Register index, taken from paddr above the byte offset
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SENT        = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_ACK_TAKEN   = 3'd2,
    ST_ACK_CORRUPT = 3'd3,
    ST_ACK_STALE   = 3'd4,
    ST_RESENT      = 3'd5,
    ST_TMO_UNKNOWN = 3'd6
  } status_t;

endpackage

>>> rtl/srsw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_req_if
// Request channel: send, acknowledgment and timeout commands.
// ----------------------------------------------------------------------------
interface srsw_req_if;
  import srsw_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SEQ_W-1:0] seq_in;
  logic             checksum_ok;
  logic [PAY_W-1:0] payload;

  modport source (output valid, cmd, seq_in, checksum_ok, payload, input ready);
  modport sink   (input valid, cmd, seq_in, checksum_ok, payload, output ready);
endinterface

>>> rtl/srsw_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_res_if
// Result channel: one beat per executed command.
// ----------------------------------------------------------------------------
interface srsw_res_if;
  import srsw_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                tx_valid;
  logic [SEQ_W-1:0]    tx_seq;
  logic [PAY_W-1:0]    tx_payload;
  logic                timer_start;
  logic                timer_stop;
  logic [SEQ_W-1:0]    timer_seq;
  logic                window_full;

  modport source (output valid, status, tx_valid, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, window_full, input ready);
  modport sink   (input valid, status, tx_valid, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, window_full, output ready);
endinterface

>>> rtl/srsw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_cfg
// APB register slave holding the window size register, with read-back.
// ----------------------------------------------------------------------------
module srsw_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srsw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [srsw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [srsw_pkg::WSIZE_W-1:0]    window_size
);
  import srsw_pkg::*;

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1];
  assign wr_en     = psel && penable && pwrite && pready;

  // window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (wr_en && reg_index == REG_WINDOW_SIZE) begin
      window_size <= pwdata[WSIZE_W-1:0];
    end
  end

  // read-back mux
  always_comb begin
    unique case (reg_index)
      REG_WINDOW_SIZE: prdata = CFG_DATA_W'(window_size);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/selective_repeat_sender_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Selective-repeat ARQ sender window: payload memory, slot valid bits,
// base/next pointers and one result beat per command other than CMD_NONE.
// ----------------------------------------------------------------------------
// A command is latched in S_IDLE and its result beat is loaded in S_EXEC once
//   the result register is free; no new command is taken until then.
// An ack that moves base with more than one packet in flight then walks the
//   slot valid bits one per cycle in S_SCAN, taking no command; no new beat.
// The payload memory read is registered, so resent data is ready in S_EXEC.
// Synchronous reset clears pointers, counters, valid bits and the result
//   valid flag; the payload memory is not cleared and needs no clearing pass.
// WINDOW_DEPTH must be a power of two (the block does not check it); the slot is the low bits of the sequence.
module selective_repeat_sender_window_core #(
  parameter int SEQ_BITS     = 8,
  parameter int WINDOW_DEPTH = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srsw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [srsw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  srsw_req_if.sink                        req,
  srsw_res_if.source                      res
);
  import srsw_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int IFW    = $clog2(WINDOW_DEPTH + 1);
  localparam int EW     = (IFW > WSIZE_W) ? IFW : WSIZE_W;
  localparam int CW     = (SEQ_BITS > IFW) ? SEQ_BITS : IFW;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

  state_t                   state;
  logic [SEQ_BITS-1:0]      base_seq;
  logic [SEQ_BITS-1:0]      next_seq;
  logic [IFW-1:0]           in_flight;
  logic                     full_flag;
  logic [WINDOW_DEPTH-1:0]  slot_valid;
  logic [WSIZE_W-1:0]       window_size;

  // latched command
  cmd_t                     cmd_r;
  logic [SEQ_BITS-1:0]      seq_r;
  logic                     ck_r;
  logic [PAYLOAD_BITS-1:0]  pay_r;

  // base advance walk
  logic [SEQ_BITS-1:0]      scan_seq;
  logic [IFW-1:0]           scan_cnt;

  // payload memory
  logic [PAYLOAD_BITS-1:0]  pay_mem [WINDOW_DEPTH];
  logic [PAYLOAD_BITS-1:0]  ram_rdata;
  logic [SLOT_W-1:0]        ram_raddr;
  logic                     ram_we;

  logic [SEQ_BITS-1:0]      seq_dist;
  logic                     in_win;
  logic [EW-1:0]            ws_ext;
  logic [EW-1:0]            eff_win;
  logic                     send_ok;
  logic [IFW-1:0]           if_inc;
  logic                     full_after;
  logic                     out_free;
  logic [SLOT_W-1:0]        slot_seq;
  logic [SLOT_W-1:0]        slot_nx;
  logic [SLOT_W-1:0]        slot_scan;

  srsw_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  // window arithmetic
  assign slot_seq  = seq_r[SLOT_W-1:0];
  assign slot_nx   = next_seq[SLOT_W-1:0];
  assign slot_scan = scan_seq[SLOT_W-1:0];
  assign seq_dist  = seq_r - base_seq;
  assign in_win    = CW'(seq_dist) < CW'(in_flight);
  assign ws_ext    = EW'(window_size);

  always_comb begin
    if (ws_ext == '0) begin
      eff_win = EW'(1);
    end else if (ws_ext > EW'(WINDOW_DEPTH)) begin
      eff_win = EW'(WINDOW_DEPTH);
    end else begin
      eff_win = ws_ext;
    end
  end

  assign send_ok    = !full_flag && (EW'(in_flight) < eff_win);
  assign if_inc     = in_flight + IFW'(1);
  assign full_after = EW'(if_inc) >= eff_win;
  assign out_free   = !res.valid || res.ready;

  assign req.ready = (state == S_IDLE);

  // payload memory: write on a taken send, read re-issued while waiting
  assign ram_raddr = (state == S_IDLE) ? req.seq_in[SLOT_W-1:0] : slot_seq;
  assign ram_we    = (state == S_EXEC) && out_free && (cmd_r == CMD_SEND) && send_ok;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      pay_mem[slot_nx] <= pay_r;
    end
    ram_rdata <= pay_mem[ram_raddr];
  end

  // control, window state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base_seq   <= '0;
      next_seq   <= '0;
      in_flight  <= '0;
      full_flag  <= 1'b0;
      slot_valid <= '0;
      res.valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_r <= cmd_t'(req.cmd);
            seq_r <= SEQ_BITS'(req.seq_in);
            ck_r  <= req.checksum_ok;
            pay_r <= PAYLOAD_BITS'(req.payload);
            if (cmd_t'(req.cmd) != CMD_NONE) begin
              state <= S_EXEC;
            end
          end
        end

        S_EXEC: begin
          if (out_free) begin
            state           <= S_IDLE;
            res.valid       <= 1'b1;
            res.tx_valid    <= 1'b0;
            res.tx_seq      <= '0;
            res.tx_payload  <= '0;
            res.timer_start <= 1'b0;
            res.timer_stop  <= 1'b0;
            res.timer_seq   <= '0;
            res.window_full <= full_flag;
            case (cmd_r)
              CMD_SEND: begin
                if (send_ok) begin
                  slot_valid[slot_nx] <= 1'b1;
                  next_seq            <= next_seq + SEQ_BITS'(1);
                  in_flight           <= if_inc;
                  full_flag           <= full_after;
                  res.window_full     <= full_after;
                  res.status          <= ST_SENT;
                  res.tx_valid        <= 1'b1;
                  res.tx_seq          <= SEQ_W'(next_seq);
                  res.tx_payload      <= PAY_W'(pay_r);
                  res.timer_start     <= 1'b1;
                  res.timer_seq       <= SEQ_W'(next_seq);
                end else begin
                  full_flag       <= 1'b1;
                  res.window_full <= 1'b1;
                  res.status      <= ST_REFUSED;
                end
              end
              CMD_ACK: begin
                if (!ck_r) begin
                  res.status <= ST_ACK_CORRUPT;
                end else if (!in_win) begin
                  res.status <= ST_ACK_STALE;
                end else begin
                  res.status           <= ST_ACK_TAKEN;
                  res.timer_stop       <= 1'b1;
                  res.timer_seq        <= SEQ_W'(seq_r);
                  slot_valid[slot_seq] <= 1'b0;
                  // ack of base: move base to the oldest outstanding packet
                  if (seq_dist == '0) begin
                    full_flag       <= 1'b0;
                    res.window_full <= 1'b0;
                    if (in_flight > IFW'(1)) begin
                      state    <= S_SCAN;
                      scan_seq <= base_seq + SEQ_BITS'(1);
                      scan_cnt <= IFW'(1);
                    end else begin
                      base_seq  <= next_seq;
                      in_flight <= '0;
                    end
                  end
                end
              end
              CMD_TIMEOUT: begin
                if (in_win && slot_valid[slot_seq]) begin
                  res.status      <= ST_RESENT;
                  res.tx_valid    <= 1'b1;
                  res.tx_seq      <= SEQ_W'(seq_r);
                  res.tx_payload  <= PAY_W'(ram_rdata);
                  res.timer_start <= 1'b1;
                  res.timer_seq   <= SEQ_W'(seq_r);
                end else begin
                  res.status <= ST_TMO_UNKNOWN;
                end
              end
              default: begin
                res.valid <= 1'b0;
              end
            endcase
          end
        end

        // walk forward one slot per cycle looking for an outstanding packet
        S_SCAN: begin
          if (slot_valid[slot_scan]) begin
            base_seq  <= scan_seq;
            in_flight <= in_flight - scan_cnt;
            state     <= S_IDLE;
          end else if (scan_cnt == in_flight - IFW'(1)) begin
            base_seq  <= next_seq;
            in_flight <= '0;
            state     <= S_IDLE;
          end else begin
            scan_seq <= scan_seq + SEQ_BITS'(1);
            scan_cnt <= scan_cnt + IFW'(1);
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= IFW'(WINDOW_DEPTH))
    else $error("in_flight exceeds window depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    SEQ_BITS'(next_seq - base_seq) == SEQ_BITS'(in_flight))
    else $error("next_seq - base_seq disagrees with in_flight");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    full_flag |-> (in_flight != '0))
    else $error("window full with nothing in flight");

  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_cnt != '0) && (scan_cnt < in_flight))
    else $error("base walk out of range");

endmodule
